[hdl/cpu8_pkg.sv]
// Types, mnemonic codes and opcode decode for the 8080 instruction predecoder.
package cpu8_pkg;

  localparam logic [7:0] OP_HLT = 8'h76;
  localparam logic [7:0] MASK_Y = 8'b0011_1000;
  localparam logic [7:0] MASK_Z = 8'b0000_0111;

  localparam logic [5:0] MN_NOP   = 6'd0,  MN_LXI   = 6'd1,  MN_STAX = 6'd2,  MN_INX  = 6'd3;
  localparam logic [5:0] MN_INR   = 6'd4,  MN_DCR   = 6'd5,  MN_MVI  = 6'd6,  MN_RLC  = 6'd7;
  localparam logic [5:0] MN_DAD   = 6'd8,  MN_LDAX  = 6'd9,  MN_DCX  = 6'd10, MN_RRC  = 6'd11;
  localparam logic [5:0] MN_RAL   = 6'd12, MN_RAR   = 6'd13, MN_SHLD = 6'd14, MN_DAA  = 6'd15;
  localparam logic [5:0] MN_LHLD  = 6'd16, MN_CMA   = 6'd17, MN_STA  = 6'd18, MN_STC  = 6'd19;
  localparam logic [5:0] MN_LDA   = 6'd20, MN_CMC   = 6'd21, MN_MOV  = 6'd22, MN_HLT  = 6'd23;
  localparam logic [5:0] MN_ADD   = 6'd24, MN_RCOND = 6'd32, MN_POP  = 6'd33, MN_JCOND = 6'd34;
  localparam logic [5:0] MN_JMP   = 6'd35, MN_CCOND = 6'd36, MN_PUSH = 6'd37, MN_ADI  = 6'd38;
  localparam logic [5:0] MN_RST   = 6'd39, MN_RET   = 6'd40, MN_CALL = 6'd41, MN_ACI  = 6'd42;
  localparam logic [5:0] MN_OUT   = 6'd43, MN_SUI   = 6'd44, MN_IN   = 6'd45, MN_SBI  = 6'd46;
  localparam logic [5:0] MN_XTHL  = 6'd47, MN_ANI   = 6'd48, MN_PCHL = 6'd49, MN_XCHG = 6'd50;
  localparam logic [5:0] MN_XRI   = 6'd51, MN_DI    = 6'd52, MN_ORI  = 6'd53, MN_SPHL = 6'd54;
  localparam logic [5:0] MN_EI    = 6'd55, MN_CPI   = 6'd56;

  localparam logic [5:0] MISC0 [8] = '{MN_RLC, MN_RRC, MN_RAL, MN_RAR,
                                       MN_DAA, MN_CMA, MN_STC, MN_CMC};
  localparam logic [5:0] IMM8  [8] = '{MN_ADI, MN_ACI, MN_SUI, MN_SBI,
                                       MN_ANI, MN_XRI, MN_ORI, MN_CPI};
  localparam logic [5:0] MEM0  [4] = '{MN_SHLD, MN_LHLD, MN_STA, MN_LDA};
  localparam logic [5:0] X3Z3  [8] = '{MN_JMP, MN_NOP, MN_OUT, MN_IN,
                                       MN_XTHL, MN_XCHG, MN_DI, MN_EI};

  typedef struct packed {
    logic [5:0] kind;
    logic [2:0] f1;
    logic [2:0] f2;
    logic [1:0] nops;
  } dec_t;

  typedef struct packed {
    logic [5:0]  mnemonic;
    logic [2:0]  first_field;
    logic [2:0]  second_field;
    logic [15:0] operand_value;
    logic [1:0]  length;
    logic        truncated;
  } res_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t       d;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    x = op[7:6];
    y = 3'((op & MASK_Y) >> 3);
    z = 3'(op & MASK_Z);
    p = y[2:1];
    q = y[0];
    d = '0;
    case (x)
      2'd1: begin
        if (op == OP_HLT) begin
          d.kind = MN_HLT;
        end else begin
          d.kind = MN_MOV;
          d.f1   = y;
          d.f2   = z;
        end
      end
      2'd2: begin
        d.kind = MN_ADD + {3'b000, y};
        d.f1   = z;
      end
      2'd0: begin
        case (z)
          3'd0: d.kind = MN_NOP;
          3'd1: begin
            d.f1 = {1'b0, p};
            if (!q) begin
              d.kind = MN_LXI;
              d.nops = 2'd2;
            end else begin
              d.kind = MN_DAD;
            end
          end
          3'd2: begin
            if (!p[1]) begin
              d.kind = q ? MN_LDAX : MN_STAX;
              d.f1   = {1'b0, p};
            end else begin
              d.kind = MEM0[y[1:0]];
              d.nops = 2'd2;
            end
          end
          3'd3: begin
            d.kind = q ? MN_DCX : MN_INX;
            d.f1   = {1'b0, p};
          end
          3'd4: begin
            d.kind = MN_INR;
            d.f1   = y;
          end
          3'd5: begin
            d.kind = MN_DCR;
            d.f1   = y;
          end
          3'd6: begin
            d.kind = MN_MVI;
            d.f1   = y;
            d.nops = 2'd1;
          end
          default: d.kind = MISC0[y];
        endcase
      end
      default: begin
        case (z)
          3'd0: begin
            d.kind = MN_RCOND;
            d.f1   = y;
          end
          3'd1: begin
            if (!q) begin
              d.kind = MN_POP;
              d.f1   = {1'b0, p};
            end else begin
              case (p)
                2'd0:    d.kind = MN_RET;
                2'd1:    d.kind = MN_NOP;
                2'd2:    d.kind = MN_PCHL;
                default: d.kind = MN_SPHL;
              endcase
            end
          end
          3'd2: begin
            d.kind = MN_JCOND;
            d.f1   = y;
            d.nops = 2'd2;
          end
          3'd3: begin
            d.kind = X3Z3[y];
            if (y == 3'd0) begin
              d.nops = 2'd2;
            end else if (y == 3'd2 || y == 3'd3) begin
              d.nops = 2'd1;
            end
          end
          3'd4: begin
            d.kind = MN_CCOND;
            d.f1   = y;
            d.nops = 2'd2;
          end
          3'd5: begin
            if (!q) begin
              d.kind = MN_PUSH;
              d.f1   = {1'b0, p};
            end else if (p == 2'd0) begin
              d.kind = MN_CALL;
              d.nops = 2'd2;
            end else begin
              d.kind = MN_NOP;
            end
          end
          3'd6: begin
            d.kind = IMM8[y];
            d.nops = 2'd1;
          end
          default: begin
            d.kind = MN_RST;
            d.f1   = y;
          end
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

[hdl/cpu8_instruction_predecoder.sv]
// 8080 instruction predecoder: one code byte per transfer in, one record per instruction out.
// Each record is registered: it goes to the output register, or to the skid register while output stalls.
// Throughput: one code byte per cycle while in_stall is low; a skid register holds one record
// while output stalls, and in_stall stays high as long as that skid register is full.
// Reset (synchronous, rst_n low): operand count and both output valid flags clear,
// so the next byte is taken as an opcode.
module cpu8_instruction_predecoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_mnemonic,
  output logic [2:0]  out_first_field,
  output logic [2:0]  out_second_field,
  output logic [15:0] out_operand_value,
  output logic [1:0]  out_length,
  output logic        out_truncated
);

  logic [1:0]        due_r, due_nxt;
  logic [7:0]        op_r, op_nxt;
  logic [7:0]        low_r, low_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  cpu8_pkg::res_t    out_r, out_nxt;
  cpu8_pkg::res_t    skid_r, skid_nxt;
  cpu8_pkg::res_t    res;
  cpu8_pkg::dec_t    dec;
  logic [7:0]        op_sel;
  logic              in_fire;
  logic              res_hit;
  logic              out_fire;

  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign op_sel   = (due_r == 2'd0) ? in_code_byte : op_r;
  assign dec      = cpu8_pkg::decode(op_sel);

  always_comb begin
    due_nxt              = due_r;
    op_nxt               = op_r;
    low_nxt              = low_r;
    res_hit              = 1'b0;
    res.mnemonic         = dec.kind;
    res.first_field      = dec.f1;
    res.second_field     = dec.f2;
    res.length           = dec.nops + 2'd1;
    res.operand_value    = '0;
    res.truncated        = 1'b0;
    if (in_fire) begin
      if (due_r == 2'd0) begin
        if (dec.nops == 2'd0) begin
          res_hit = 1'b1;
        end else if (in_final_byte) begin
          res_hit       = 1'b1;
          res.truncated = 1'b1;
        end else begin
          op_nxt  = in_code_byte;
          low_nxt = '0;
          due_nxt = dec.nops;
        end
      end else if (dec.nops == 2'd2 && due_r == 2'd2) begin
        low_nxt = in_code_byte;
        due_nxt = 2'd1;
        if (in_final_byte) begin
          res_hit           = 1'b1;
          res.operand_value = {8'h00, in_code_byte};
          res.truncated     = 1'b1;
        end
      end else if (dec.nops == 2'd2) begin
        res_hit           = 1'b1;
        res.operand_value = {in_code_byte, low_r};
        due_nxt           = 2'd0;
      end else begin
        res_hit           = 1'b1;
        res.operand_value = {8'h00, in_code_byte};
        due_nxt           = 2'd0;
      end
      if (in_final_byte) begin
        due_nxt = 2'd0;
        op_nxt  = '0;
        low_nxt = '0;
      end
    end
  end

  // advance output register, park in skid when output holds
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || res_hit;
      out_nxt        = skid_valid_r ? skid_r : res;
      skid_valid_nxt = 1'b0;
    end else if (res_hit) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r        <= 2'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      due_r        <= due_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    low_r  <= low_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall          = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_mnemonic      = out_r.mnemonic;
  assign out_first_field   = out_r.first_field;
  assign out_second_field  = out_r.second_field;
  assign out_operand_value = out_r.operand_value;
  assign out_length        = out_r.length;
  assign out_truncated     = out_r.truncated;

endmodule

[bench/testbench.sv]
// Self-checking bench for the 8080 instruction predecoder: directed table, sweep, random code.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1350;
  localparam int CALM_TAIL   = 150;
  localparam int LONG_HOLD   = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int ROWS        = 26;

  typedef struct packed {
    logic [7:0]     code;
    logic           fin;
    logic           typed;
    cpu8_pkg::res_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_code_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_mnemonic;
  logic [2:0]  out_first_field;
  logic [2:0]  out_second_field;
  logic [15:0] out_operand_value;
  logic [1:0]  out_length;
  logic        out_truncated;

  cpu8_pkg::res_t pending_records [$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          sender_gaps = 1'b1;
  bit          hold_long = 1'b0;

  logic [1:0]  due_count = 2'd0;
  logic [7:0]  held_op = 8'h00;
  logic [7:0]  held_lo = 8'h00;

  stim_row_t directed_rows [0:ROWS-1] = '{
    {8'h00, 1'b0, 1'b1, cpu8_pkg::MN_NOP,  3'd0, 3'd0, 16'h0000, 2'd1, 1'b0},
    {8'hff, 1'b0, 1'b1, cpu8_pkg::MN_RST,  3'd7, 3'd0, 16'h0000, 2'd1, 1'b0},
    {8'h76, 1'b0, 1'b1, cpu8_pkg::MN_HLT,  3'd0, 3'd0, 16'h0000, 2'd1, 1'b0},
    {8'h40, 1'b0, 1'b1, cpu8_pkg::MN_MOV,  3'd0, 3'd0, 16'h0000, 2'd1, 1'b0},
    {8'h7f, 1'b0, 1'b1, cpu8_pkg::MN_MOV,  3'd7, 3'd7, 16'h0000, 2'd1, 1'b0},
    {8'hfe, 1'b0, 1'b0, 31'd0},
    {8'h55, 1'b0, 1'b1, cpu8_pkg::MN_CPI,  3'd0, 3'd0, 16'h0055, 2'd2, 1'b0},
    {8'hde, 1'b0, 1'b0, 31'd0},
    {8'haa, 1'b0, 1'b1, cpu8_pkg::MN_SBI,  3'd0, 3'd0, 16'h00aa, 2'd2, 1'b0},
    {8'hcb, 1'b0, 1'b1, cpu8_pkg::MN_NOP,  3'd0, 3'd0, 16'h0000, 2'd1, 1'b0},
    {8'hc3, 1'b0, 1'b0, 31'd0},
    {8'h34, 1'b0, 1'b0, 31'd0},
    {8'h12, 1'b0, 1'b1, cpu8_pkg::MN_JMP,  3'd0, 3'd0, 16'h1234, 2'd3, 1'b0},
    {8'hcd, 1'b1, 1'b1, cpu8_pkg::MN_CALL, 3'd0, 3'd0, 16'h0000, 2'd3, 1'b1},
    {8'h3a, 1'b0, 1'b0, 31'd0},
    {8'hab, 1'b1, 1'b1, cpu8_pkg::MN_LDA,  3'd0, 3'd0, 16'h00ab, 2'd3, 1'b1},
    {8'h06, 1'b1, 1'b1, cpu8_pkg::MN_MVI,  3'd0, 3'd0, 16'h0000, 2'd2, 1'b1},
    {8'h31, 1'b0, 1'b0, 31'd0},
    {8'hff, 1'b0, 1'b0, 31'd0},
    {8'hff, 1'b1, 1'b1, cpu8_pkg::MN_LXI,  3'd3, 3'd0, 16'hffff, 2'd3, 1'b0},
    {8'hd3, 1'b0, 1'b0, 31'd0},
    {8'h00, 1'b1, 1'b0, 31'd0},
    {8'h80, 1'b1, 1'b0, 31'd0},
    {8'hc4, 1'b0, 1'b0, 31'd0},
    {8'h00, 1'b0, 1'b0, 31'd0},
    {8'h80, 1'b0, 1'b0, 31'd0}
  };

  cpu8_instruction_predecoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_byte      (in_code_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mnemonic      (out_mnemonic),
    .out_first_field   (out_first_field),
    .out_second_field  (out_second_field),
    .out_operand_value (out_operand_value),
    .out_length        (out_length),
    .out_truncated     (out_truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // kind, register fields and operand byte count of one opcode
  function automatic void decode_opcode(input logic [7:0] op, output logic [5:0] kind,
                                        output logic [2:0] reg_a, output logic [2:0] reg_b,
                                        output logic [1:0] extra);
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    y = op[5:3];
    z = op[2:0];
    p = y[2:1];
    q = y[0];
    kind  = cpu8_pkg::MN_NOP;
    reg_a = 3'd0;
    reg_b = 3'd0;
    extra = 2'd0;
    case (op[7:6])
      2'd1: begin
        if (op == cpu8_pkg::OP_HLT) begin
          kind = cpu8_pkg::MN_HLT;
        end else begin
          kind  = cpu8_pkg::MN_MOV;
          reg_a = y;
          reg_b = z;
        end
      end
      2'd2: begin
        kind  = cpu8_pkg::MN_ADD + 6'(y);
        reg_a = z;
      end
      2'd0: begin
        case (z)
          3'd0: kind = cpu8_pkg::MN_NOP;
          3'd1: begin
            reg_a = {1'b0, p};
            kind  = q ? cpu8_pkg::MN_DAD : cpu8_pkg::MN_LXI;
            extra = q ? 2'd0 : 2'd2;
          end
          3'd2: begin
            if (!p[1]) begin
              kind  = q ? cpu8_pkg::MN_LDAX : cpu8_pkg::MN_STAX;
              reg_a = {1'b0, p};
            end else begin
              extra = 2'd2;
              case (y[1:0])
                2'd0: kind = cpu8_pkg::MN_SHLD;
                2'd1: kind = cpu8_pkg::MN_LHLD;
                2'd2: kind = cpu8_pkg::MN_STA;
                default: kind = cpu8_pkg::MN_LDA;
              endcase
            end
          end
          3'd3: begin
            kind  = q ? cpu8_pkg::MN_DCX : cpu8_pkg::MN_INX;
            reg_a = {1'b0, p};
          end
          3'd4: begin
            kind  = cpu8_pkg::MN_INR;
            reg_a = y;
          end
          3'd5: begin
            kind  = cpu8_pkg::MN_DCR;
            reg_a = y;
          end
          3'd6: begin
            kind  = cpu8_pkg::MN_MVI;
            reg_a = y;
            extra = 2'd1;
          end
          default: begin
            case (y)
              3'd0: kind = cpu8_pkg::MN_RLC;
              3'd1: kind = cpu8_pkg::MN_RRC;
              3'd2: kind = cpu8_pkg::MN_RAL;
              3'd3: kind = cpu8_pkg::MN_RAR;
              3'd4: kind = cpu8_pkg::MN_DAA;
              3'd5: kind = cpu8_pkg::MN_CMA;
              3'd6: kind = cpu8_pkg::MN_STC;
              default: kind = cpu8_pkg::MN_CMC;
            endcase
          end
        endcase
      end
      default: begin
        case (z)
          3'd0: begin
            kind  = cpu8_pkg::MN_RCOND;
            reg_a = y;
          end
          3'd1: begin
            if (!q) begin
              kind  = cpu8_pkg::MN_POP;
              reg_a = {1'b0, p};
            end else begin
              case (p)
                2'd0: kind = cpu8_pkg::MN_RET;
                2'd1: kind = cpu8_pkg::MN_NOP;
                2'd2: kind = cpu8_pkg::MN_PCHL;
                default: kind = cpu8_pkg::MN_SPHL;
              endcase
            end
          end
          3'd2: begin
            kind  = cpu8_pkg::MN_JCOND;
            reg_a = y;
            extra = 2'd2;
          end
          3'd3: begin
            case (y)
              3'd0: begin
                kind  = cpu8_pkg::MN_JMP;
                extra = 2'd2;
              end
              3'd1: kind = cpu8_pkg::MN_NOP;
              3'd2: begin
                kind  = cpu8_pkg::MN_OUT;
                extra = 2'd1;
              end
              3'd3: begin
                kind  = cpu8_pkg::MN_IN;
                extra = 2'd1;
              end
              3'd4: kind = cpu8_pkg::MN_XTHL;
              3'd5: kind = cpu8_pkg::MN_XCHG;
              3'd6: kind = cpu8_pkg::MN_DI;
              default: kind = cpu8_pkg::MN_EI;
            endcase
          end
          3'd4: begin
            kind  = cpu8_pkg::MN_CCOND;
            reg_a = y;
            extra = 2'd2;
          end
          3'd5: begin
            if (!q) begin
              kind  = cpu8_pkg::MN_PUSH;
              reg_a = {1'b0, p};
            end else if (p == 2'd0) begin
              kind  = cpu8_pkg::MN_CALL;
              extra = 2'd2;
            end else begin
              kind = cpu8_pkg::MN_NOP;
            end
          end
          3'd6: begin
            extra = 2'd1;
            case (y)
              3'd0: kind = cpu8_pkg::MN_ADI;
              3'd1: kind = cpu8_pkg::MN_ACI;
              3'd2: kind = cpu8_pkg::MN_SUI;
              3'd3: kind = cpu8_pkg::MN_SBI;
              3'd4: kind = cpu8_pkg::MN_ANI;
              3'd5: kind = cpu8_pkg::MN_XRI;
              3'd6: kind = cpu8_pkg::MN_ORI;
              default: kind = cpu8_pkg::MN_CPI;
            endcase
          end
          default: begin
            kind  = cpu8_pkg::MN_RST;
            reg_a = y;
          end
        endcase
      end
    endcase
  endfunction

  function automatic cpu8_pkg::res_t build_record(input logic [7:0] op,
                                                  input logic [15:0] value,
                                                  input logic trunc);
    logic [5:0] kind;
    logic [2:0] reg_a;
    logic [2:0] reg_b;
    logic [1:0] extra;
    decode_opcode(op, kind, reg_a, reg_b, extra);
    return {kind, reg_a, reg_b, value, 2'(extra + 2'd1), trunc};
  endfunction

  // advance the decoder state by one code byte
  task automatic predict_record(input logic [7:0] b, input logic fin, output bit made,
                                output cpu8_pkg::res_t rec);
    logic [5:0] kind;
    logic [2:0] reg_a;
    logic [2:0] reg_b;
    logic [1:0] extra;
    made = 1'b0;
    rec  = '0;
    if (due_count == 2'd0) begin
      decode_opcode(b, kind, reg_a, reg_b, extra);
      if (extra == 2'd0 || fin) begin
        rec  = build_record(b, 16'h0000, extra != 2'd0);
        made = 1'b1;
      end else begin
        held_op   = b;
        held_lo   = 8'h00;
        due_count = extra;
      end
    end else begin
      decode_opcode(held_op, kind, reg_a, reg_b, extra);
      if (extra == 2'd2 && due_count == 2'd2) begin
        held_lo   = b;
        due_count = 2'd1;
        if (fin) begin
          rec  = build_record(held_op, {8'h00, b}, 1'b1);
          made = 1'b1;
        end
      end else begin
        rec       = build_record(held_op, (extra == 2'd2) ? {b, held_lo} : {8'h00, b}, 1'b0);
        made      = 1'b1;
        due_count = 2'd0;
      end
    end
    if (fin) begin
      due_count = 2'd0;
      held_op   = 8'h00;
      held_lo   = 8'h00;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
                           input cpu8_pkg::res_t given);
    bit             made;
    cpu8_pkg::res_t rec;
    if (bytes_sent % 80 == 0) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
    end
    calm = (bytes_sent >= ITEM_TARGET - CALM_TAIL);
    if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_code_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_record(b, fin, made, rec);
    if (made) begin
      pending_records.push_back(typed ? given : rec);
    end
    bytes_sent++;
  endtask

  // one opcode followed by its operand bytes; a final mark may cut it short
  task automatic send_instruction(input logic [7:0] op, input int end_odds);
    logic [5:0] kind;
    logic [2:0] reg_a;
    logic [2:0] reg_b;
    logic [1:0] extra;
    logic       fin;
    decode_opcode(op, kind, reg_a, reg_b, extra);
    fin = ($urandom_range(0, end_odds) == 0);
    send_item(op, fin, 1'b0, '0);
    for (int i = 0; i < extra && !fin; i++) begin
      fin = ($urandom_range(0, end_odds) == 0);
      send_item(8'($urandom), fin, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cpu8_pkg::res_t got;
    cpu8_pkg::res_t want;
    got = {out_mnemonic, out_first_field, out_second_field, out_operand_value,
           out_length, out_truncated};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual %p", $time, got);
        error_count++;
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          $display("%0t: record mismatch, expected %p, actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  initial begin
    int stall_len;
    wait (rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        stall_len = 0;
        while (stall_len < LONG_HOLD) begin
          @(posedge clk);
          stall_len++;
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      send_item(directed_rows[r].code, directed_rows[r].fin, directed_rows[r].typed,
                directed_rows[r].want);
    end

    hold_long = 1'b1;
    for (int op = 0; op < 256; op++) begin
      send_instruction(8'(op), 60);
    end

    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        send_instruction(8'($urandom), 25);
      end else begin
        send_item(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/cpu8_pkg.sv
hdl/cpu8_instruction_predecoder.sv
bench/testbench.sv
